// File: sv/bprm_pkg.sv
// Shared types and constants for the bad-pixel row median filter.
`default_nettype none
package bprm_pkg;
    localparam int PIX_W = 16;
    localparam int COL_W = 12;
    localparam int RAD_W = 8;
    localparam int ROWW_W = 13;
    localparam int MAX_ROW_WIDTH = 4096;

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_COMPUTE = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_GATHER,
        ST_DRAIN,
        ST_PICK,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic clear;
        logic ins;
    } t_cell_ctl;
endpackage
`default_nettype wire

// File: sv/bprm_ram.sv
// Generic single-port RAM with registered read.
`default_nettype none
module bprm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  wire                     i_clk,
    input  wire                     i_we,
    input  wire [$clog2(DEPTH)-1:0] i_addr,
    input  wire [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]        o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire

// File: sv/bprm_cell.sv
// One cell of the insertion sorter: holds one sorted value.
`default_nettype none
module bprm_cell import bprm_pkg::*; (
    input  wire              i_clk,
    input  t_cell_ctl        i_ctl,
    input  wire [PIX_W-1:0]  i_new,
    input  wire              i_prev_full,
    input  wire              i_prev_gt,
    input  wire [PIX_W-1:0]  i_prev_val,
    output logic             o_full,
    output logic             o_gt,
    output logic [PIX_W-1:0] o_val
);
    logic             r_full;
    logic [PIX_W-1:0] r_val;

    assign o_full = r_full;
    assign o_val  = r_val;
    assign o_gt   = r_full && (r_val > i_new);

    always_ff @(posedge i_clk) begin
        if (i_ctl.clear) begin
            r_full <= 1'b0;
        end else if (i_ctl.ins) begin
            if (o_gt) begin
                r_val <= (i_prev_gt) ? i_prev_val : i_new;
            end else if (!r_full && i_prev_full && !i_prev_gt) begin
                r_val  <= i_new;
                r_full <= 1'b1;
            end else if (!r_full && i_prev_gt) begin
                r_val  <= i_prev_val;
                r_full <= 1'b1;
            end
        end
    end
endmodule
`default_nettype wire

// File: sv/bad_pixel_row_median.sv
// Top level of the bad-pixel row median filter.
// A write beat stores a pixel. A compute beat with radius r > 0 reads the
// 2r+1 window pixels from the single-port row RAM one per cycle and inserts
// each into a chain of sorting cells, then takes the cell of rank r.
// A column at or beyond the row width yields no result beat.
`default_nettype none
module bad_pixel_row_median import bprm_pkg::*; #(
    parameter int MAX_RADIUS = 127
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire [15:0]  i_cfg_data,     // row_width [12:0]
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire [39:0]  s_axis_tdata,   // column, pixel_value, radius
    input  wire         s_axis_tuser,   // req_type
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [31:0] m_axis_tdata    // out_column, filtered_value
);
    localparam int AW = $clog2(MAX_ROW_WIDTH);
    localparam int NC = 2 * MAX_RADIUS + 1;
    localparam int CW = $clog2(NC + 1);
    localparam int SW = AW + 2;

    t_state r_state, n_state;
    logic [ROWW_W-1:0] r_width;
    logic [COL_W-1:0]  r_col;
    logic [RAD_W-1:0]  r_rad;
    logic [CW-1:0]     r_cnt;
    logic              r_pend;
    logic [PIX_W-1:0]  r_res;

    logic [COL_W-1:0] in_col;
    logic [PIX_W-1:0] in_pix;
    logic [RAD_W-1:0] in_rad, rad_cap;
    logic [ROWW_W-1:0] w_eff;
    logic s_acc;

    assign in_col = s_axis_tdata[11:0];
    assign in_pix = s_axis_tdata[27:12];
    assign in_rad = s_axis_tdata[35:28];
    assign rad_cap = (in_rad > RAD_W'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS) : in_rad;
    assign w_eff = (r_width == '0) ? ROWW_W'(1) :
                   (r_width > ROWW_W'(MAX_ROW_WIDTH)) ? ROWW_W'(MAX_ROW_WIDTH) : r_width;

    assign o_cfg_ready = (r_state == ST_IDLE) && !m_axis_tvalid;
    assign s_acc = s_axis_tvalid && s_axis_tready;

    // window address of slot k: k<r -> col+k+1, k<2r -> col-(k-r+1), else col+r+1
    logic signed [SW-1:0] a_raw;
    logic [AW-1:0] addr;
    logic [CW-1:0] rr;
    assign rr = CW'(r_rad);
    always_comb begin
        if (r_cnt < rr) begin
            a_raw = SW'(r_col) + SW'(r_cnt) + SW'(1);
        end else if (r_cnt < (rr << 1)) begin
            a_raw = SW'(r_col) - SW'(r_cnt - rr) - SW'(1);
        end else begin
            a_raw = SW'(r_col) + SW'(rr) + SW'(1);
        end
        if (a_raw < 0) begin
            addr = '0;
        end else if (a_raw > SW'(w_eff) - SW'(1)) begin
            addr = AW'(w_eff - ROWW_W'(1));
        end else begin
            addr = AW'(a_raw);
        end
    end

    logic ram_we;
    logic [AW-1:0] ram_addr;
    logic [PIX_W-1:0] ram_q;
    assign ram_we = s_acc && (s_axis_tuser == REQ_WRITE);
    assign ram_addr = s_acc ? AW'(in_col) :
                      (r_state == ST_CLEAR) ? AW'(r_col) : addr;

    bprm_ram #(.WIDTH(PIX_W), .DEPTH(MAX_ROW_WIDTH)) u_ram (
        .i_clk(i_clk), .i_we(ram_we), .i_addr(ram_addr),
        .i_wdata(in_pix), .o_rdata(ram_q)
    );

    t_cell_ctl ctl;
    assign ctl.clear = (r_state == ST_CLEAR);
    assign ctl.ins = r_pend;

    logic [NC:0] full, gt;
    logic [PIX_W-1:0] val [NC+1];
    assign full[0] = 1'b1;
    assign gt[0] = 1'b0;
    assign val[0] = '0;

    for (genvar g = 0; g < NC; g++) begin : g_cell
        bprm_cell u_cell (
            .i_clk(i_clk), .i_ctl(ctl), .i_new(ram_q),
            .i_prev_full(full[g]), .i_prev_gt(gt[g]), .i_prev_val(val[g]),
            .o_full(full[g+1]), .o_gt(gt[g+1]), .o_val(val[g+1])
        );
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:   if (s_acc && s_axis_tuser == REQ_COMPUTE &&
                           ROWW_W'(in_col) < w_eff) n_state = ST_CLEAR;
            ST_CLEAR:  n_state = (r_rad == '0) ? ST_PICK : ST_GATHER;
            ST_GATHER: if (r_cnt == (rr << 1)) n_state = ST_DRAIN;
            ST_DRAIN:  n_state = ST_PICK;
            ST_PICK:   n_state = ST_OUT;
            ST_OUT:    if (!m_axis_tvalid || m_axis_tready) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        s_axis_tready = (r_state == ST_IDLE) && !i_cfg_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_width <= ROWW_W'(4096);
            r_pend <= 1'b0;
            m_axis_tvalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) r_width <= i_cfg_data[ROWW_W-1:0];
            r_pend <= (r_state == ST_GATHER);
            if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
            if (r_state == ST_OUT && n_state == ST_IDLE) m_axis_tvalid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_col <= in_col;
            r_rad <= rad_cap;
        end
        r_cnt <= (r_state == ST_GATHER) ? r_cnt + CW'(1) : '0;
        if (r_state == ST_PICK) begin
            r_res <= (r_rad == '0) ? ram_q : val[r_rad + RAD_W'(1)];
        end
        if (r_state == ST_OUT && n_state == ST_IDLE) begin
            m_axis_tdata <= {4'b0, r_res, r_col};
        end
    end

    ap_idle_cfg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !s_axis_tready) else $error("busy but ready");
    ap_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
        else $error("result changed under stall");
    ap_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_GATHER) |-> (r_cnt <= (rr << 1))) else $error("count overrun");
endmodule
`default_nettype wire

// File: tb/sv/bad_pixel_row_median_test.sv
// Testbench for the bad-pixel row median filter: directed and random traffic checked against a row model.
module bad_pixel_row_median_test import bprm_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ROW_MAX = 4096;
    localparam int RAD_MAX = 127;
    localparam int QUIET_LIMIT = 20000;

    typedef struct packed {
        logic       req;
        logic [11:0] col;
        logic [15:0] pix;
        logic [7:0]  rad;
    } t_beat;

    typedef struct packed {
        logic [15:0] val;
        logic [11:0] col;
    } t_median;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [15:0] i_cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;

    bad_pixel_row_median dut (.*);

    t_beat   pending_beats[$];
    t_median expected_medians[$];
    logic [15:0] row_pixels [ROW_MAX];
    int          row_span;
    int          mismatches;
    int          quiet_cycles;
    int          tx_gap;
    int          rx_gap;
    int          hold_off;
    bit          calm;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [15:0] pixel_at(int c);
        if (c < 0) c = 0;
        if (c > row_span - 1) c = row_span - 1;
        return row_pixels[c];
    endfunction

    function automatic void predict_median(t_beat b);
        logic [15:0] win[$];
        int r;
        int c;
        t_median m;
        if (b.req == REQ_WRITE) begin
            row_pixels[b.col] = b.pix;
            return;
        end
        c = int'(b.col);
        if (c >= row_span) return;
        r = (int'(b.rad) > RAD_MAX) ? RAD_MAX : int'(b.rad);
        m.col = b.col;
        if (r == 0) begin
            m.val = row_pixels[c];
        end else begin
            for (int i = 1; i <= r; i++) begin
                win.push_back(pixel_at(c + i));
                win.push_back(pixel_at(c - i));
            end
            win.push_back(pixel_at(c + r + 1));
            win.sort();
            m.val = win[r];
        end
        expected_medians.push_back(m);
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        mismatches++;
    endtask

    // Driver.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            tx_gap <= 0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            t_beat acc;
            if (s_axis_tvalid) begin
                acc.req = s_axis_tuser;
                acc.col = s_axis_tdata[11:0];
                acc.pix = s_axis_tdata[27:12];
                acc.rad = s_axis_tdata[35:28];
                predict_median(acc);
            end
            if (tx_gap > 0) begin
                s_axis_tvalid <= 1'b0;
                tx_gap <= tx_gap - 1;
            end else if (pending_beats.size() > 0) begin
                t_beat b;
                b = pending_beats.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tuser <= b.req;
                s_axis_tdata <= {4'b0, b.rad, b.pix, b.col};
                if (!calm && $urandom_range(0, 5) == 0) tx_gap <= $urandom_range(1, 7);
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Monitor and receiver stalls.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            rx_gap <= 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                t_median got;
                t_median want;
                got = m_axis_tdata[27:0];
                if (expected_medians.size() == 0) begin
                    report_mismatch("unexpected beat column", int'(got.col), -1);
                end else begin
                    want = expected_medians.pop_front();
                    if (got.col !== want.col)
                        report_mismatch("column", int'(got.col), int'(want.col));
                    if (got.val !== want.val)
                        report_mismatch("value", int'(got.val), int'(want.val));
                end
            end
            if (hold_off > 0) begin
                m_axis_tready <= 1'b0;
                hold_off <= hold_off - 1;
            end else if (rx_gap > 0) begin
                m_axis_tready <= 1'b0;
                rx_gap <= rx_gap - 1;
            end else begin
                m_axis_tready <= 1'b1;
                if (!calm && $urandom_range(0, 5) == 0) rx_gap <= $urandom_range(1, 7);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("bad_pixel_row_median_test NOT OK");
            $finish;
        end
    end

    function automatic t_beat write_beat(int c, int p);
        t_beat b;
        b.req = REQ_WRITE;
        b.col = 12'(c);
        b.pix = 16'(p);
        b.rad = 8'($urandom);
        return b;
    endfunction

    function automatic t_beat compute_beat(int c, int r);
        t_beat b;
        b.req = REQ_COMPUTE;
        b.col = 12'(c);
        b.pix = 16'($urandom);
        b.rad = 8'(r);
        return b;
    endfunction

    task automatic settle();
        while (pending_beats.size() > 0 || s_axis_tvalid || expected_medians.size() > 0)
            @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    task automatic set_row_width(int w);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= 16'(w);
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        row_span = (w == 0) ? 1 : ((w > ROW_MAX) ? ROW_MAX : w);
    endtask

    // Fill the whole row so that no compute reads an unwritten entry.
    task automatic fill_row(int span);
        for (int c = 0; c < span; c++) pending_beats.push_back(write_beat(c, $urandom));
    endtask

    task automatic random_phase(int span, int n);
        for (int k = 0; k < n; k++) begin
            int r;
            if ($urandom_range(0, 3) == 0) begin
                pending_beats.push_back(write_beat($urandom_range(0, span - 1), $urandom));
            end else begin
                case ($urandom_range(0, 9))
                    0: r = $urandom_range(128, 255);
                    1: r = 0;
                    2: r = $urandom_range(100, 127);
                    default: r = $urandom_range(1, 12);
                endcase
                pending_beats.push_back(compute_beat($urandom_range(0, span - 1), r));
            end
        end
    endtask

    initial begin
        int span;
        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        m_axis_tready = 1'b0;
        mismatches = 0;
        quiet_cycles = 0;
        hold_off = 0;
        calm = 1'b0;
        row_span = ROW_MAX;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: extremes at default width, then narrow row.
        pending_beats.push_back(write_beat(0, 16'hFFFF));
        pending_beats.push_back(write_beat(1, 0));
        pending_beats.push_back(write_beat(2, 16'h5555));
        pending_beats.push_back(write_beat(4095, 16'hAAAA));
        pending_beats.push_back(write_beat(4094, 16'h1234));
        pending_beats.push_back(compute_beat(0, 0));
        pending_beats.push_back(compute_beat(4095, 0));
        pending_beats.push_back(compute_beat(4095, 1));
        pending_beats.push_back(compute_beat(0, 1));
        settle();

        set_row_width(16);
        fill_row(16);
        pending_beats.push_back(compute_beat(0, 255));
        pending_beats.push_back(compute_beat(15, 127));
        pending_beats.push_back(compute_beat(7, 128));
        pending_beats.push_back(compute_beat(16, 3));
        pending_beats.push_back(compute_beat(4095, 3));
        pending_beats.push_back(write_beat(4095, 16'h8001));
        pending_beats.push_back(compute_beat(3, 2));
        settle();

        set_row_width(0);
        pending_beats.push_back(compute_beat(0, 5));
        pending_beats.push_back(compute_beat(1, 0));
        settle();
        set_row_width(8191);
        pending_beats.push_back(compute_beat(4095, 1));
        settle();

        // Long receiver hold-off while the sender keeps offering.
        set_row_width(40);
        fill_row(40);
        settle();
        random_phase(40, 30);
        hold_off = 3000;
        settle();

        for (int ph = 0; ph < 4; ph++) begin
            span = $urandom_range(2, 100);
            set_row_width(span);
            fill_row(span);
            random_phase(span, 150);
            settle();
        end

        calm = 1'b1;
        set_row_width(64);
        fill_row(64);
        random_phase(64, 150);
        settle();

        if (mismatches == 0)
            $display("bad_pixel_row_median_test OK");
        else
            $display("bad_pixel_row_median_test NOT OK");
        $finish;
    end
endmodule
